// ----- rtl/vdc_pkg.sv -----
// Package for the vigilance dead-man controller: mode codes, register
// indexes, reset values and the transaction payload types.
// No dependencies.
package vdc_pkg;

  // Operating modes, encoded as seen on the result mode field
  typedef enum logic [2:0] {
    MODE_OFF            = 3'd0,
    MODE_HOLD           = 3'd1,
    MODE_HOLD_ALARM     = 3'd2,
    MODE_RELEASED       = 3'd3,
    MODE_RELEASED_ALARM = 3'd4,
    MODE_EMERGENCY      = 3'd5
  } mode_e;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_HOLD_DELAY    = 2'd0,
    REG_RELEASE_DELAY = 2'd1,
    REG_ALARM_DUR     = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_e;

  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SPEED_W   = 9;

  localparam logic [TIME_W-1:0] HOLD_DELAY_RST    = 32'd55000;
  localparam logic [TIME_W-1:0] RELEASE_DELAY_RST = 32'd5000;
  localparam logic [TIME_W-1:0] ALARM_DUR_RST     = 32'd5000;

  // One evaluation tick
  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [SPEED_W-1:0] veh_speed;
    logic               zone_switch_on;
    logic               pedal_held;
    logic               emergency_active;
  } vdc_in_t;

  // One result per tick
  typedef struct packed {
    logic [2:0] mode;
    logic       hold_alarm;
    logic       release_alarm;
    logic       brake_request;
  } vdc_out_t;

endpackage

// ----- rtl/vdc_if.sv -----
// Valid/ready channel interfaces for tick inputs and results.
// Depends on vdc_pkg.
interface vdc_in_if import vdc_pkg::*; ();
  logic    valid;
  logic    ready;
  vdc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vdc_out_if import vdc_pkg::*; ();
  logic     valid;
  logic     ready;
  vdc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/vigilance_deadman_controller_top.sv -----
// Vigilance dead-man controller, top level.
// Ticks pass the input register, then the result register; a result waits there while results stall.
// Throughput: one tick per cycle while results are taken; the mode/mark update is a single add, compare and select.
// Reset (rst_ni, async, active low): mode off, mark time zero, delays 55000/5000/5000 ms,
// both channel stages empty.
// Depends on vdc_pkg and the interfaces in vdc_if.sv.
module vigilance_deadman_controller_top
  import vdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  vdc_in_if.sink             in_ch,
  vdc_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Configuration registers
  logic [TIME_W-1:0] hold_delay_q, release_delay_q, alarm_dur_q;
  reg_idx_e          reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_delay_q    <= HOLD_DELAY_RST;
      release_delay_q <= RELEASE_DELAY_RST;
      alarm_dur_q     <= ALARM_DUR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HOLD_DELAY:    hold_delay_q    <= pwdata;
        REG_RELEASE_DELAY: release_delay_q <= pwdata;
        REG_ALARM_DUR:     alarm_dur_q     <= pwdata;
        default:           ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_HOLD_DELAY:    prdata = hold_delay_q;
      REG_RELEASE_DELAY: prdata = release_delay_q;
      REG_ALARM_DUR:     prdata = alarm_dur_q;
      default:           prdata = '0;
    endcase
  end

  // Pipeline handshake: input register feeds the result register
  logic    s1_valid_q, out_valid_q;
  vdc_in_t s1_q;
  logic    advance, out_free;

  assign out_free     = !out_valid_q || out_ch.ready;
  assign advance      = s1_valid_q && out_free;
  assign in_ch.ready  = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_q <= in_ch.data;
    end
  end

  // Mode and mark-time state
  mode_e             mode_q, mode_d;
  logic [TIME_W-1:0] mark_q, mark_d;
  logic              brake_d;
  logic [TIME_W-1:0] delay_sel, deadline;
  logic              expired, armed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OFF;
      mark_q <= '0;
    end else if (advance) begin
      mode_q <= mode_d;
      mark_q <= mark_d;
    end
  end

  // Timeout test against the delay that belongs to the current mode
  always_comb begin
    case (mode_q)
      MODE_HOLD:           delay_sel = hold_delay_q;
      MODE_RELEASED:       delay_sel = release_delay_q;
      MODE_HOLD_ALARM,
      MODE_RELEASED_ALARM: delay_sel = alarm_dur_q;
      default:             delay_sel = '0;
    endcase
  end

  assign deadline = mark_q + delay_sel;
  assign expired  = s1_q.now_ms > deadline;
  assign armed    = (s1_q.veh_speed != '0) || s1_q.zone_switch_on;

  // Next mode (hold, released and alarm modes): disarm first, then timeout, then pedal change
  always_comb begin
    mode_d  = mode_q;
    mark_d  = mark_q;
    brake_d = 1'b0;
    case (mode_q)
      MODE_OFF: begin
        if (armed) begin
          mode_d = s1_q.pedal_held ? MODE_HOLD : MODE_RELEASED;
          mark_d = s1_q.now_ms;
        end
      end
      MODE_HOLD: begin
        if (!armed) begin
          mode_d = MODE_OFF;
        end else if (expired) begin
          mode_d = MODE_HOLD_ALARM;
          mark_d = s1_q.now_ms;
        end else if (!s1_q.pedal_held) begin
          mode_d = MODE_RELEASED;
          mark_d = s1_q.now_ms;
        end
      end
      MODE_RELEASED: begin
        if (!armed) begin
          mode_d = MODE_OFF;
        end else if (expired) begin
          mode_d = MODE_RELEASED_ALARM;
          mark_d = s1_q.now_ms;
        end else if (s1_q.pedal_held) begin
          mode_d = MODE_HOLD;
          mark_d = s1_q.now_ms;
        end
      end
      MODE_HOLD_ALARM: begin
        if (!armed) begin
          mode_d = MODE_OFF;
        end else if (expired) begin
          mode_d  = MODE_EMERGENCY;
          brake_d = 1'b1;
        end else if (!s1_q.pedal_held) begin
          mode_d = MODE_RELEASED;
          mark_d = s1_q.now_ms;
        end
      end
      MODE_RELEASED_ALARM: begin
        if (!armed) begin
          mode_d = MODE_OFF;
        end else if (expired) begin
          mode_d  = MODE_EMERGENCY;
          brake_d = 1'b1;
        end else if (s1_q.pedal_held) begin
          mode_d = MODE_HOLD;
          mark_d = s1_q.now_ms;
        end
      end
      MODE_EMERGENCY: begin
        if (!s1_q.emergency_active) begin
          mode_d = MODE_OFF;
        end
      end
      default: begin
        mode_d = MODE_OFF;
      end
    endcase
  end

  // Result register
  vdc_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.mode          <= mode_d;
      out_q.hold_alarm    <= (mode_d == MODE_HOLD_ALARM);
      out_q.release_alarm <= (mode_d == MODE_RELEASED_ALARM);
      out_q.brake_request <= brake_d;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

  // Assertions
  a_brake_in_emerg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.brake_request |-> out_q.mode == MODE_EMERGENCY)
    else $error("brake request outside emergency mode");

  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.mode == mode_q)
    else $error("held result mode differs from state");

  a_alarm_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.hold_alarm == (out_q.mode == MODE_HOLD_ALARM)) &&
                    (out_q.release_alarm == (out_q.mode == MODE_RELEASED_ALARM)))
    else $error("alarm flags disagree with mode");

  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while result side is ready");

  a_brake_from_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && brake_d |=> $past(mode_q) == MODE_HOLD_ALARM ||
                           $past(mode_q) == MODE_RELEASED_ALARM)
    else $error("brake request not from an alarm mode");

endmodule
